>>> hdl/tle_pkg.sv
// shared types, constants and helpers of the terminal line editor
`default_nettype none

package tle_pkg;

	// default line store depth in bytes
	localparam int unsigned DEF_LINE_DEPTH = 1024;

	// result field widths
	localparam int unsigned KIND_W = 2;
	localparam int unsigned LEN_W  = 11;

	// command queue depth is 2**CMDQ_AW
	localparam int unsigned CMDQ_AW = 2;

	// byte codes
	localparam logic [7:0] CH_BS      = 8'd8;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_ESC     = 8'd27;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_ONE     = 8'd49;
	localparam logic [7:0] CH_SEMI    = 8'd59;
	localparam logic [7:0] CH_LBRACK  = 8'd91;
	localparam logic [7:0] CH_DEL     = 8'd127;

	// escape count at which a long sequence ends
	localparam logic [2:0] ESC_LONG_END = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

	// commands from the front to the back
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_ERASE = 2'd1,
		OP_CHECK = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        out_byte;
		logic [LEN_W-1:0]  line_length;
		logic              last_of_run;
	} res_t;

	// tab, newline, vertical tab, form feed, carriage return, space
	function automatic logic is_space(input logic [7:0] b);
		return b inside {[8'd9:8'd13], CH_SPACE};
	endfunction

endpackage

`default_nettype wire

>>> hdl/tle_in_if.sv
// input byte channel of the terminal line editor
`default_nettype none

interface tle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/tle_out_if.sv
// result channel of the terminal line editor
`default_nettype none

interface tle_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [10:0] line_length;
	logic        last_of_run;

	modport source (output valid, output kind, output out_byte, output line_length,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input out_byte, input line_length,
		input last_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/tle_ram.sv
// generic single port ram with registered read
`default_nettype none

module tle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  addr,
	input  wire [WIDTH-1:0]          wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/tle_front.sv
// front end: escape sequence filter and command classification
`default_nettype none

module tle_front import tle_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	tle_in_if.sink     keys,
	output logic       cmd_valid,
	input  wire        cmd_ready,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		ESC_NORMAL  = 4'b0001,
		ESC_ESC     = 4'b0010,
		ESC_BRACKET = 4'b0100,
		ESC_LONG    = 4'b1000
	} esc_state_t;

	esc_state_t esc_state_q;
	logic [2:0] esc_cnt_q;
	logic       accept;
	logic [7:0] b;

	assign b          = keys.in_byte;
	assign keys.ready = cmd_ready;
	assign accept     = keys.valid && cmd_ready;

	// classify the byte into a command for the back end
	always_comb begin
		cmd.data  = b;
		cmd.op    = OP_CHECK;
		cmd_valid = 1'b0;
		if (esc_state_q == ESC_NORMAL) begin
			cmd_valid = accept && (b != CH_ESC);
			cmd.op    = (b == CH_BS || b == CH_DEL) ? OP_ERASE : OP_PUSH;
		end else begin
			cmd_valid = accept && (b == CH_NEWLINE);
		end
	end

	// escape filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_state_q <= ESC_NORMAL;
			esc_cnt_q   <= 3'd0;
		end else if (accept) begin
			case (esc_state_q)
				ESC_NORMAL: begin
					if (b == CH_ESC) begin
						esc_state_q <= ESC_ESC;
						esc_cnt_q   <= 3'd0;
					end
				end
				ESC_ESC: begin
					if (b == CH_LBRACK) begin
						esc_state_q <= ESC_BRACKET;
						esc_cnt_q   <= 3'd1;
					end else begin
						esc_state_q <= ESC_NORMAL;
						esc_cnt_q   <= 3'd0;
					end
				end
				ESC_BRACKET: begin
					if (b == CH_ONE) begin
						esc_state_q <= ESC_LONG;
						esc_cnt_q   <= esc_cnt_q + 3'd1;
					end else begin
						esc_state_q <= ESC_NORMAL;
						esc_cnt_q   <= 3'd0;
					end
				end
				ESC_LONG: begin
					if (esc_cnt_q >= ESC_LONG_END) begin
						esc_state_q <= ESC_NORMAL;
						esc_cnt_q   <= 3'd0;
					end else begin
						esc_cnt_q   <= esc_cnt_q + 3'd1;
					end
				end
				default: begin
					esc_state_q <= ESC_NORMAL;
					esc_cnt_q   <= 3'd0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/tle_cmdq.sv
// short command queue between front and back end
`default_nettype none

module tle_cmdq import tle_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push_valid,
	output logic  push_ready,
	input  cmd_t  push_cmd,
	output logic  pop_valid,
	input  wire   pop_ready,
	output cmd_t  pop_cmd
);

	localparam int unsigned DEPTH = 1 << CMDQ_AW;

	cmd_t               entry_q [DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = fill_q != (CMDQ_AW + 1)'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (CMDQ_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (CMDQ_AW + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/tle_back.sv
// back end: line store, erase, line completion and result sequencing
`default_nettype none

module tle_back import tle_pkg::*; #(
	parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	tle_out_if.source   results
);

	localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
	localparam int unsigned AW = $clog2(LINE_DEPTH);
	localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_ERASE = 3'b010,
		B_LINE  = 3'b100
	} back_state_t;

	back_state_t      state_q;
	logic             step_q;
	logic [CW-1:0]    count_q;
	logic             top_flag_q;
	logic             load_q;
	logic             res_valid_q;
	res_t             res_q;
	logic [LEN_W-1:0] line_len_q;

	logic             ob_free;
	logic             pop;
	logic             full;
	logic             is_nl;
	logic             new_flag;
	logic [CW-1:0]    cnt_p1;
	logic [CW-1:0]    cnt_m2;
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic             ram_rdata;
	logic             emit_en;
	res_t             emit_res;
	logic             go_line;
	logic [LEN_W-1:0] pend_len;

	// line length as the low bits of the stored count
	function automatic logic [LEN_W-1:0] len_of(input logic [CW-1:0] c);
		logic [LW-1:0] e;
		e = LW'(c);
		return e[LEN_W-1:0];
	endfunction

	assign ob_free   = !res_valid_q || results.ready;
	assign cmd_ready = (state_q == B_IDLE) && ob_free;
	assign pop       = cmd_valid && cmd_ready;
	assign full      = count_q == CW'(LINE_DEPTH);
	assign is_nl     = cmd.data == CH_NEWLINE;
	assign cnt_p1    = count_q + CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	// flag per entry: last non-whitespace byte up to here is a semicolon
	assign new_flag  = is_space(cmd.data) ? top_flag_q : (cmd.data == CH_SEMI);

	// store write on push, read of the new top entry on erase
	assign ram_we   = pop && (cmd.op == OP_PUSH) && !full;
	assign ram_addr = ram_we ? count_q[AW-1:0] : cnt_m2[AW-1:0];

	tle_ram #(
		.WIDTH (1),
		.DEPTH (LINE_DEPTH)
	) u_flag_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (new_flag),
		.rdata (ram_rdata)
	);

	// result selection
	always_comb begin
		emit_en              = 1'b0;
		emit_res.kind        = KIND_ECHO;
		emit_res.out_byte    = '0;
		emit_res.line_length = '0;
		emit_res.last_of_run = 1'b1;
		go_line              = 1'b0;
		pend_len             = len_of(count_q);
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					case (cmd.op)
						OP_PUSH: begin
							emit_en = 1'b1;
							if (!full) begin
								go_line           = is_nl && new_flag;
								pend_len          = len_of(cnt_p1);
								emit_res.out_byte = cmd.data;
							end else begin
								go_line       = is_nl && top_flag_q;
								emit_res.kind = KIND_DROP;
							end
							emit_res.last_of_run = !go_line;
						end
						OP_ERASE: begin
							emit_en              = count_q != '0;
							emit_res.out_byte    = CH_BS;
							emit_res.last_of_run = 1'b0;
						end
						OP_CHECK: begin
							emit_en              = (count_q != '0) && top_flag_q;
							emit_res.kind        = KIND_LINE;
							emit_res.line_length = len_of(count_q);
						end
						default: begin
							emit_en = 1'b0;
						end
					endcase
				end
			end
			B_ERASE: begin
				emit_en              = ob_free;
				emit_res.out_byte    = step_q ? CH_BS : CH_SPACE;
				emit_res.last_of_run = step_q;
			end
			B_LINE: begin
				emit_en              = ob_free;
				emit_res.kind        = KIND_LINE;
				emit_res.line_length = line_len_q;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// result and pending length payload
	always_ff @(posedge clk) begin
		if (emit_en) begin
			res_q <= emit_res;
		end
		if (go_line) begin
			line_len_q <= pend_len;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= 1'b0;
			count_q     <= '0;
			top_flag_q  <= 1'b0;
			load_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_en) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			if (load_q) begin
				top_flag_q <= ram_rdata;
				load_q     <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (cmd.op)
							OP_PUSH: begin
								if (go_line) begin
									count_q    <= '0;
									top_flag_q <= 1'b0;
									state_q    <= B_LINE;
								end else if (!full) begin
									count_q    <= cnt_p1;
									top_flag_q <= new_flag;
								end
							end
							OP_ERASE: begin
								if (count_q != '0) begin
									count_q <= count_q - CW'(1);
									if (count_q >= CW'(2)) begin
										load_q <= 1'b1;
									end else begin
										top_flag_q <= 1'b0;
									end
									step_q  <= 1'b0;
									state_q <= B_ERASE;
								end
							end
							OP_CHECK: begin
								if (emit_en) begin
									count_q    <= '0;
									top_flag_q <= 1'b0;
								end
							end
							default: begin
								state_q <= B_IDLE;
							end
						endcase
					end
				end
				B_ERASE: begin
					if (ob_free) begin
						if (!step_q) begin
							step_q <= 1'b1;
						end else begin
							state_q <= B_IDLE;
						end
					end
				end
				B_LINE: begin
					if (ob_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign results.valid       = res_valid_q;
	assign results.kind        = res_q.kind;
	assign results.out_byte    = res_q.out_byte;
	assign results.line_length = res_q.line_length;
	assign results.last_of_run = res_q.last_of_run;

endmodule

`default_nettype wire

>>> hdl/terminal_line_editor.sv
// Terminal line editor: takes raw keyboard bytes on the keys channel and
// returns echo, line-complete and dropped-byte beats on the results channel.
// Each result beat carries last_of_run on the final beat caused by one byte;
// bytes swallowed by the escape filter and erase on an empty line give none.
// The front end accepts one byte per cycle while its four-entry command queue
// has room; the escape filter runs there and needs no buffer access.
// The back end takes one command per cycle while it is idle and its output
// register is free: a stored byte gives its echo in the cycle after the back
// end takes it, a completed line adds one more beat after that one, and an
// erase gives its three beats in turn. Line completion needs no backward
// scan: each stored entry keeps a flag telling whether the last non-whitespace
// byte up to it is a semicolon, so a newline is decided from the flag of the
// top entry alone.
// An erase reads the flag of the new top entry from the single-port flag ram.
// The results channel has an output register: a stall there holds the beat
// and backs up into the queue and then the keys channel, with no loss.
// Reset clears the escape filter, the queue and the stored count; the flag
// ram needs no clearing since only entries below the count are read.
`default_nettype none

module terminal_line_editor import tle_pkg::*; #(
	parameter int unsigned LINE_DEPTH = DEF_LINE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	tle_in_if.sink     keys,
	tle_out_if.source  results
);

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	tle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.keys      (keys),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	tle_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	tle_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.results   (results)
	);

endmodule

`default_nettype wire

>>> tb/terminal_line_editor_tb.sv
// testbench for the terminal line editor: keyboard byte stimulus, line prediction, result checks
module terminal_line_editor_tb import tle_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_DEPTH   = DEF_LINE_DEPTH;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned RANDOM_RUNS  = 130;
	localparam logic [7:0]  CH_TAB       = 8'd9;

	// escape filter states of the line predictor
	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_SEEN,
		ESC_BRACKET,
		ESC_LONG
	} esc_state_t;

	logic clk;
	logic arst_n;
	logic sink_ready = 1'b0;

	tle_in_if  keys_if ();
	tle_out_if res_if ();

	assign res_if.ready = sink_ready;

	terminal_line_editor #(.LINE_DEPTH(LINE_DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys_if),
		.results (res_if)
	);

	// predicted editor state
	esc_state_t  esc_state;
	logic [2:0]  esc_cnt;
	logic [7:0]  line_chars [LINE_DEPTH];
	int unsigned line_len;

	// beats still owed by the editor, oldest first
	res_t due_beats [$];

	int unsigned errors      = 0;
	int unsigned cycles      = 0;
	int unsigned productive  = 0;
	int unsigned burst_left  = 0;
	int unsigned stall_left  = 0;
	bit          pace_on     = 1'b1;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic res_t make_beat(input logic [1:0] kind, input logic [7:0] ch,
		input logic [10:0] len);
		res_t r;
		r.kind        = kind;
		r.out_byte    = ch;
		r.line_length = len;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// apply one key to the predicted line, queue the beats it causes
	function automatic int unsigned edit_line(input logic [7:0] b);
		res_t        run [$];
		int unsigned i;
		logic [7:0]  last;
		case (esc_state)
			ESC_IDLE: begin
				if (b == CH_ESC) begin
					esc_state = ESC_SEEN;
					esc_cnt   = '0;
				end else if (b == CH_BS || b == CH_DEL) begin
					if (line_len > 0) begin
						line_len--;
						run.push_back(make_beat(KIND_ECHO, CH_BS, '0));
						run.push_back(make_beat(KIND_ECHO, CH_SPACE, '0));
						run.push_back(make_beat(KIND_ECHO, CH_BS, '0));
					end
				end else if (line_len >= LINE_DEPTH) begin
					run.push_back(make_beat(KIND_DROP, 8'd0, '0));
				end else begin
					line_chars[line_len] = b;
					line_len++;
					run.push_back(make_beat(KIND_ECHO, b, '0));
				end
			end
			ESC_SEEN: begin
				if (b == CH_LBRACK) begin
					esc_state = ESC_BRACKET;
					esc_cnt   = 3'd1;
				end else begin
					esc_state = ESC_IDLE;
					esc_cnt   = '0;
				end
			end
			ESC_BRACKET: begin
				if (b == CH_ONE) begin
					esc_state = ESC_LONG;
					esc_cnt   = esc_cnt + 3'd1;
				end else begin
					esc_state = ESC_IDLE;
					esc_cnt   = '0;
				end
			end
			default: begin
				if (esc_cnt >= ESC_LONG_END) begin
					esc_state = ESC_IDLE;
					esc_cnt   = '0;
				end else begin
					esc_cnt = esc_cnt + 3'd1;
				end
			end
		endcase

		// newline: look back for the last non-blank byte
		if (b == CH_NEWLINE) begin
			last = CH_SPACE;
			i    = line_len;
			while (i > 0) begin
				i--;
				if (!is_blank(line_chars[i])) begin
					last = line_chars[i];
					break;
				end
			end
			if (last == CH_SEMI) begin
				run.push_back(make_beat(KIND_LINE, 8'd0, 11'(line_len)));
				line_len = 0;
			end
		end

		if (run.size() > 0)
			run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[k])
			due_beats.push_back(run[k]);
		return run.size();
	endfunction

	// send one key beat, predict on acceptance, then maybe pause
	task automatic send_key(input logic [7:0] b);
		int unsigned gap;
		keys_if.valid   <= 1'b1;
		keys_if.in_byte <= b;
		do
			@(posedge clk);
		while (!keys_if.ready);
		if (edit_line(b) > 0)
			productive++;
		if (pace_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap        = $urandom_range(1, 6);
				keys_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// byte extremes, erase with and without stored bytes
	task automatic test_echo_and_erase();
		send_key(CH_BS);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(CH_DEL);
		send_key(CH_BS);
		send_key(CH_BS);
	endtask

	// short, bracket and long escape sequences
	task automatic test_escape_filter();
		send_key(CH_ESC);
		send_key(CH_LBRACK);
		send_key(CH_ONE);
		send_key(CH_SEMI);
		send_key("5");
		send_key("D");
		send_key("q");
		send_key(CH_ESC);
		send_key("A");
		send_key(CH_ESC);
		send_key(CH_LBRACK);
		send_key("C");
		send_key(CH_ESC);
		send_key(CH_DEL);
		send_key(CH_ESC);
		send_key(CH_ESC);
		send_key("r");
	endtask

	// newline with and without a closing semicolon, blanks, newline inside an escape
	task automatic test_line_end();
		send_key(CH_NEWLINE);
		send_key(CH_SEMI);
		send_key(CH_SPACE);
		send_key(CH_NEWLINE);
		send_key(CH_TAB);
		send_key(CH_NEWLINE);
		send_key(CH_SEMI);
		send_key(CH_ESC);
		send_key(CH_NEWLINE);
		send_key(CH_ESC);
		send_key(CH_NEWLINE);
	endtask

	// fill the line, drop bytes, erase at full, complete a full line
	task automatic test_buffer_full();
		logic [7:0] b;
		repeat (LINE_DEPTH - 2) begin
			do
				b = 8'($urandom);
			while (b == CH_BS || b == CH_DEL || b == CH_ESC || b == CH_NEWLINE);
			send_key(b);
		end
		send_key(CH_SEMI);
		send_key("x");
		send_key("y");
		send_key(CH_NEWLINE);
		send_key(CH_DEL);
		send_key(CH_SEMI);
		send_key(CH_NEWLINE);
	endtask

	// random typing: words, escapes, erases, line ends and noise
	task automatic test_random_typing();
		int unsigned start;
		start = productive;
		while (productive - start < RANDOM_RUNS) begin
			if ($urandom_range(0, 29) == 0)
				pace_on = ~pace_on;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(32, 126)));
				end
				4: begin
					send_key(CH_ESC);
					case ($urandom_range(0, 3))
						0: send_key($urandom_range(0, 1) ? 8'($urandom_range(48, 57))
							: 8'($urandom_range(97, 122)));
						1: begin
							send_key(CH_LBRACK);
							send_key(8'($urandom_range(65, 68)));
						end
						2: begin
							send_key(CH_LBRACK);
							send_key(CH_ONE);
							repeat (3) send_key(8'($urandom));
						end
						default: send_key(8'($urandom));
					endcase
				end
				5: begin
					repeat ($urandom_range(1, 3)) send_key($urandom_range(0, 1) ? CH_BS : CH_DEL);
				end
				6: begin
					send_key(CH_SEMI);
					repeat ($urandom_range(0, 2)) send_key($urandom_range(0, 1) ? CH_SPACE
						: 8'($urandom_range(9, 13)));
					send_key(CH_NEWLINE);
				end
				7: begin
					repeat ($urandom_range(0, 2)) send_key(CH_TAB);
					send_key(CH_NEWLINE);
				end
				default: send_key(8'($urandom_range(0, 255)));
			endcase
		end
		pace_on = 1'b1;
	endtask

	// result side stalls while pacing is on
	always @(posedge clk) begin
		if (!pace_on) begin
			sink_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 5);
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest owed beat
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat: kind %0d byte %0d length %0d last %0d",
					$time, res_if.kind, res_if.out_byte, res_if.line_length,
					res_if.last_of_run);
				errors++;
			end else begin
				want = due_beats.pop_front();
				if (res_if.kind !== want.kind) begin
					$display("%0t: kind: expected %0d, got %0d", $time, want.kind, res_if.kind);
					errors++;
				end
				if (res_if.out_byte !== want.out_byte) begin
					$display("%0t: out_byte: expected %0d, got %0d", $time, want.out_byte,
						res_if.out_byte);
					errors++;
				end
				if (res_if.line_length !== want.line_length) begin
					$display("%0t: line_length: expected %0d, got %0d", $time,
						want.line_length, res_if.line_length);
					errors++;
				end
				if (res_if.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run: expected %0d, got %0d", $time,
						want.last_of_run, res_if.last_of_run);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		keys_if.valid   <= 1'b0;
		keys_if.in_byte <= 8'd0;
		esc_state = ESC_IDLE;
		esc_cnt   = '0;
		line_len  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_echo_and_erase();
		test_escape_filter();
		test_line_end();
		test_buffer_full();
		test_random_typing();

		// drain the owed beats, then watch for strays
		keys_if.valid <= 1'b0;
		while (due_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
